// File: hdl/nps_pkg.sv
// Shared types and constants for the nearest point search block.
// No dependencies; used by every module under hdl/.
`default_nettype none

package nps_pkg;

    localparam int COORD_W = 20;
    localparam int AXIS_W  = 20;          // per-axis absolute difference
    localparam int DIST_W  = 22;
    localparam int IDX_W   = 10;          // reported index width
    localparam int SQ_W    = 2 * AXIS_W;

    localparam logic [COORD_W-1:0] RADIUS_RST = 20'd1024;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_NEAR  = 2'd2,
        CMD_ALL   = 2'd3
    } t_cmd;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_NONE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SQR,
        ST_CMP,
        ST_RESP,
        ST_TIE_RD,
        ST_TIE_WAIT
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] mdist;
        logic [AXIS_W-1:0] dx;
        logic [AXIS_W-1:0] dy;
    } t_dist_res;

endpackage

`default_nettype wire

// File: hdl/nps_point_store.sv
// Point table: one synchronous memory holding x and y of each point.
// One write port, one read port with registered read data. Uses nps_pkg.
`default_nettype none

module nps_point_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic [AW-1:0]                     i_waddr,
    input  wire logic [2*nps_pkg::COORD_W-1:0]     i_wdata,
    input  wire logic                              i_re,
    input  wire logic [AW-1:0]                     i_raddr,
    output logic      [2*nps_pkg::COORD_W-1:0]     o_rdata
);

    logic [2*nps_pkg::COORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/nps_tie_store.sv
// Tie list: synchronous memory of point indices at the least distance.
// One write port, one read port with registered read data. Uses nps_pkg.
`default_nettype none

module nps_tie_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [AW-1:0]              i_waddr,
    input  wire logic [nps_pkg::IDX_W-1:0]  i_wdata,
    input  wire logic                       i_re,
    input  wire logic [AW-1:0]              i_raddr,
    output logic      [nps_pkg::IDX_W-1:0]  o_rdata
);

    logic [nps_pkg::IDX_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/nps_dist.sv
// Two-stage taxicab distance pipeline: per-axis |diff|, then the sum.
// Uses nps_pkg for widths and the result struct.
`default_nettype none

module nps_dist (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic signed [nps_pkg::COORD_W-1:0] i_px,
    input  wire logic signed [nps_pkg::COORD_W-1:0] i_py,
    input  wire logic signed [nps_pkg::COORD_W-1:0] i_qx,
    input  wire logic signed [nps_pkg::COORD_W-1:0] i_qy,
    output logic                                   o_busy,
    output nps_pkg::t_dist_res                     o_res
);

    logic                          r_v1;
    logic [nps_pkg::AXIS_W-1:0]    r_dx1;
    logic [nps_pkg::AXIS_W-1:0]    r_dy1;
    logic                          r_v2;
    logic [nps_pkg::DIST_W-1:0]    r_sum2;
    logic [nps_pkg::AXIS_W-1:0]    r_dx2;
    logic [nps_pkg::AXIS_W-1:0]    r_dy2;
    logic [nps_pkg::AXIS_W:0]      dx_a;
    logic [nps_pkg::AXIS_W:0]      dx_b;
    logic [nps_pkg::AXIS_W:0]      dy_a;
    logic [nps_pkg::AXIS_W:0]      dy_b;
    logic [nps_pkg::AXIS_W-1:0]    n_dx1;
    logic [nps_pkg::AXIS_W-1:0]    n_dy1;

    // both orders in parallel, keep the non-negative one
    always_comb begin
        dx_a  = {i_px[nps_pkg::COORD_W-1], i_px} - {i_qx[nps_pkg::COORD_W-1], i_qx};
        dx_b  = {i_qx[nps_pkg::COORD_W-1], i_qx} - {i_px[nps_pkg::COORD_W-1], i_px};
        dy_a  = {i_py[nps_pkg::COORD_W-1], i_py} - {i_qy[nps_pkg::COORD_W-1], i_qy};
        dy_b  = {i_qy[nps_pkg::COORD_W-1], i_qy} - {i_py[nps_pkg::COORD_W-1], i_py};
        n_dx1 = dx_a[nps_pkg::AXIS_W] ? dx_b[nps_pkg::AXIS_W-1:0] : dx_a[nps_pkg::AXIS_W-1:0];
        n_dy1 = dy_a[nps_pkg::AXIS_W] ? dy_b[nps_pkg::AXIS_W-1:0] : dy_a[nps_pkg::AXIS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx1  <= n_dx1;
        r_dy1  <= n_dy1;
        r_sum2 <= nps_pkg::DIST_W'(r_dx1) + nps_pkg::DIST_W'(r_dy1);
        r_dx2  <= r_dx1;
        r_dy2  <= r_dy1;
    end

    assign o_res  = {r_v2, r_sum2, r_dx2, r_dy2};
    assign o_busy = r_v1 | r_v2;

endmodule

`default_nettype wire

// File: hdl/nearest_point_search.sv
// Nearest point search top level: control FSM, best/tie tracking, result register.
// Depends on nps_pkg, nps_point_store, nps_tie_store, nps_dist.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+----------------------------------------
//  s_axis    | in        | tvalid/tready           | tuser=command, tdata=coord_x,coord_y
//  m_axis    | out       | tvalid/tready, tlast    | tuser=status,truncated, tdata=idx,dist
//  cfg       | in        | i_cfg_we                | i_cfg_wdata=hit_radius
//
// Load, clear, query on an empty table: accept, then result load.
// Nearest query: accept, table reads, drain, radius check (square, compare), result load.
// All-nearest query: accept, table reads, drain, then per tie a read and a result load. One item at a time.
// Reset (i_rst_n low, synchronous) empties the table and sets hit_radius to 1024.
// A stalled m_axis holds the result register and the FSM waits on it.
`default_nettype none

module nearest_point_search #(
    parameter int CAPACITY = 1024,
    parameter int MAX_TIES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // [19:0] coord_x, [39:20] coord_y
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [9:0] point_index, [31:10] manhattan_dist
    output logic [2:0]       m_axis_tuser,   // [1:0] status, [2] truncated
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [19:0] i_cfg_wdata     // hit_radius
);

    localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int TW  = (MAX_TIES > 1) ? $clog2(MAX_TIES) : 1;
    localparam int TCW = $clog2(MAX_TIES + 1);

    localparam int CWD = nps_pkg::COORD_W;
    localparam int DW  = nps_pkg::DIST_W;
    localparam int AXW = nps_pkg::AXIS_W;
    localparam int XW  = nps_pkg::IDX_W;
    localparam int SQW = nps_pkg::SQ_W;

    nps_pkg::t_state r_state;
    nps_pkg::t_state n_state;

    logic [CW-1:0]           r_count;
    logic [CWD-1:0]          r_radius;
    logic signed [CWD-1:0]   r_qx;
    logic signed [CWD-1:0]   r_qy;
    logic                    r_all;
    logic [IW-1:0]           r_rd_addr;
    logic                    r_rdv;
    logic [IW-1:0]           r_cmp_idx;
    logic [DW-1:0]           r_best_d;
    logic [IW-1:0]           r_best_idx;
    logic [AXW-1:0]          r_bdx;
    logic [AXW-1:0]          r_bdy;
    logic [TCW-1:0]          r_tie_cnt;
    logic                    r_trunc;
    logic [TCW-1:0]          r_k;
    logic [SQW-1:0]          r_sqx;
    logic [SQW-1:0]          r_sqy;
    logic [SQW-1:0]          r_sqr;
    logic [1:0]              r_rs_status;
    logic [XW-1:0]           r_rs_idx;
    logic [DW-1:0]           r_rs_dist;
    logic                    r_ovalid;
    logic [1:0]              r_ostatus;
    logic [XW-1:0]           r_oidx;
    logic [DW-1:0]           r_odist;
    logic                    r_otrunc;
    logic                    r_olast;

    logic                    accept;
    logic                    full;
    logic                    out_free;
    logic                    out_load;
    logic                    pt_re;
    logic                    tie_re;
    logic                    scan_end;
    logic                    tie_last;
    logic                    tie_we;
    logic [TW-1:0]           tie_waddr;
    logic                    cmp_first;
    logic                    cmp_less;
    logic                    cmp_eq;
    logic                    pt_we;
    nps_pkg::t_cmd           cmd;
    logic [2*CWD-1:0]        pt_rdata;
    logic [XW-1:0]           tie_rdata;
    logic                    dist_busy;
    nps_pkg::t_dist_res      dres;

    assign cmd       = nps_pkg::t_cmd'(s_axis_tuser);
    assign accept    = s_axis_tvalid & s_axis_tready;
    assign full      = (r_count == CW'(CAPACITY));
    assign out_free  = ~r_ovalid | m_axis_tready;
    assign scan_end  = (CW'(r_rd_addr) + CW'(1)) == r_count;
    assign tie_last  = (r_k + TCW'(1)) == r_tie_cnt;
    assign pt_we     = accept & (cmd == nps_pkg::CMD_LOAD) & ~full;

    // ---------------------------------------------------------------- FSM
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nps_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if ((cmd == nps_pkg::CMD_LOAD) || (cmd == nps_pkg::CMD_CLEAR) ||
                        (r_count == '0)) begin
                        n_state = nps_pkg::ST_RESP;
                    end else begin
                        n_state = nps_pkg::ST_SCAN;
                    end
                end
            end
            nps_pkg::ST_SCAN: begin
                if (scan_end) n_state = nps_pkg::ST_DRAIN;
            end
            nps_pkg::ST_DRAIN: begin
                if (!r_rdv && !dist_busy) begin
                    n_state = r_all ? nps_pkg::ST_TIE_RD : nps_pkg::ST_SQR;
                end
            end
            nps_pkg::ST_SQR:  n_state = nps_pkg::ST_CMP;
            nps_pkg::ST_CMP:  n_state = nps_pkg::ST_RESP;
            nps_pkg::ST_RESP: begin
                if (out_free) n_state = nps_pkg::ST_IDLE;
            end
            nps_pkg::ST_TIE_RD: n_state = nps_pkg::ST_TIE_WAIT;
            nps_pkg::ST_TIE_WAIT: begin
                if (out_free) n_state = tie_last ? nps_pkg::ST_IDLE : nps_pkg::ST_TIE_RD;
            end
            default: n_state = nps_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        pt_re         = 1'b0;
        tie_re        = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            nps_pkg::ST_IDLE:     s_axis_tready = 1'b1;
            nps_pkg::ST_SCAN:     pt_re         = 1'b1;
            nps_pkg::ST_RESP:     out_load      = out_free;
            nps_pkg::ST_TIE_RD:   tie_re        = 1'b1;
            nps_pkg::ST_TIE_WAIT: out_load      = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nps_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_radius <= nps_pkg::RADIUS_RST;
            r_rdv    <= 1'b0;
        end else begin
            if (i_cfg_we) r_radius <= i_cfg_wdata;
            r_rdv <= pt_re;
            if (accept) begin
                unique case (cmd)
                    nps_pkg::CMD_LOAD:  if (!full) r_count <= r_count + CW'(1);
                    nps_pkg::CMD_CLEAR: r_count <= '0;
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- accept decode
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_qx      <= s_axis_tdata[CWD-1:0];
            r_qy      <= s_axis_tdata[2*CWD-1:CWD];
            r_all     <= (cmd == nps_pkg::CMD_ALL);
            r_rd_addr <= '0;
            r_cmp_idx <= '0;
            r_rs_idx  <= '0;
            r_rs_dist <= '0;
            unique case (cmd)
                nps_pkg::CMD_LOAD: begin
                    r_rs_status <= full ? nps_pkg::STAT_FULL : nps_pkg::STAT_OK;
                    if (!full) r_rs_idx <= XW'(r_count);
                end
                nps_pkg::CMD_CLEAR: r_rs_status <= nps_pkg::STAT_OK;
                default:            r_rs_status <= nps_pkg::STAT_NONE;
            endcase
        end else begin
            if (pt_re) r_rd_addr <= r_rd_addr + IW'(1);
            if (dres.valid) r_cmp_idx <= r_cmp_idx + IW'(1);
            if (r_state == nps_pkg::ST_CMP) begin
                if ((SQW + 1)'(r_sqx) + (SQW + 1)'(r_sqy) > (SQW + 1)'(r_sqr)) begin
                    r_rs_status <= nps_pkg::STAT_NONE;
                    r_rs_idx    <= '0;
                    r_rs_dist   <= '0;
                end else begin
                    r_rs_status <= nps_pkg::STAT_OK;
                    r_rs_idx    <= XW'(r_best_idx);
                    r_rs_dist   <= r_best_d;
                end
            end
        end
    end

    // ---------------------------------------------------------------- best and ties
    assign cmp_first = (r_cmp_idx == '0);
    assign cmp_less  = cmp_first || (dres.mdist < r_best_d);
    assign cmp_eq    = (dres.mdist == r_best_d);
    assign tie_waddr = cmp_less ? '0 : r_tie_cnt[TW-1:0];
    assign tie_we    = dres.valid & r_all &
                       (cmp_less | (cmp_eq & (r_tie_cnt < TCW'(MAX_TIES))));

    always_ff @(posedge i_clk) begin
        if (dres.valid && cmp_less) begin
            r_best_d   <= dres.mdist;
            r_best_idx <= r_cmp_idx;
            r_bdx      <= dres.dx;
            r_bdy      <= dres.dy;
        end
        if (r_state == nps_pkg::ST_SQR) begin
            r_sqx <= SQW'(r_bdx) * SQW'(r_bdx);
            r_sqy <= SQW'(r_bdy) * SQW'(r_bdy);
            r_sqr <= SQW'(r_radius) * SQW'(r_radius);
        end
        if (r_state == nps_pkg::ST_DRAIN) begin
            r_k <= '0;
        end else if ((r_state == nps_pkg::ST_TIE_WAIT) && out_free) begin
            r_k <= r_k + TCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tie_cnt <= '0;
            r_trunc   <= 1'b0;
        end else if (accept && (cmd == nps_pkg::CMD_CLEAR)) begin
            r_tie_cnt <= '0;
        end else if (dres.valid && r_all) begin
            if (cmp_less) begin
                r_tie_cnt <= TCW'(1);
                r_trunc   <= 1'b0;
            end else if (cmp_eq) begin
                if (r_tie_cnt < TCW'(MAX_TIES)) begin
                    r_tie_cnt <= r_tie_cnt + TCW'(1);
                end else begin
                    r_trunc <= 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (r_state == nps_pkg::ST_TIE_WAIT) begin
                r_ostatus <= nps_pkg::STAT_OK;
                r_oidx    <= tie_rdata;
                r_odist   <= r_best_d;
                r_otrunc  <= r_trunc;
                r_olast   <= tie_last;
            end else begin
                r_ostatus <= r_rs_status;
                r_oidx    <= r_rs_idx;
                r_odist   <= r_rs_dist;
                r_otrunc  <= 1'b0;
                r_olast   <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_odist, r_oidx};
    assign m_axis_tuser  = {r_otrunc, r_ostatus};
    assign m_axis_tlast  = r_olast;

    // ---------------------------------------------------------------- submodules
    nps_point_store #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_points (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (pt_re),
        .i_raddr (r_rd_addr),
        .o_rdata (pt_rdata)
    );

    nps_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rdv),
        .i_px    (pt_rdata[CWD-1:0]),
        .i_py    (pt_rdata[2*CWD-1:CWD]),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_busy  (dist_busy),
        .o_res   (dres)
    );

    nps_tie_store #(
        .DEPTH (MAX_TIES),
        .AW    (TW)
    ) u_ties (
        .i_clk   (i_clk),
        .i_we    (tie_we),
        .i_waddr (tie_waddr),
        .i_wdata (XW'(r_cmp_idx)),
        .i_re    (tie_re),
        .i_raddr (r_k[TW-1:0]),
        .o_rdata (tie_rdata)
    );

endmodule

`default_nettype wire

// File: tb/search_check_pkg.sv
// Result prediction and checking for the nearest point search testbench.
// Depends on nps_pkg (command enum, status codes, field widths).
`timescale 1ns / 1ps

package search_check_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int TIE_LIMIT   = 64;

    typedef struct packed {
        logic [1:0]                 status;
        logic [nps_pkg::IDX_W-1:0]  point_index;
        logic [nps_pkg::DIST_W-1:0] mdist;
        logic                       truncated;
        logic                       last;
    } t_search_result;

    class t_nearest_scoreboard;
        longint         px[TABLE_DEPTH];
        longint         py[TABLE_DEPTH];
        int unsigned    stored_points;
        longint         radius;
        int unsigned    failures;
        t_search_result awaited[$];

        function new();
            stored_points = 0;
            radius        = longint'(nps_pkg::RADIUS_RST);
            failures      = 0;
        endfunction

        function void set_radius(logic [nps_pkg::COORD_W-1:0] value);
            radius = longint'(value);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function void queue_result(logic [1:0] status, int unsigned idx, longint mdist,
                                   bit truncated, bit last);
            t_search_result r;
            r.status      = status;
            r.point_index = nps_pkg::IDX_W'(idx);
            r.mdist       = nps_pkg::DIST_W'(mdist);
            r.truncated   = truncated;
            r.last        = last;
            awaited.insert(awaited.size(), r);
        endfunction

        // Called for every accepted input transaction, in acceptance order.
        function void note_command(nps_pkg::t_cmd cmd, logic [nps_pkg::COORD_W-1:0] x,
                                   logic [nps_pkg::COORD_W-1:0] y);
            longint      qx;
            longint      qy;
            longint      d;
            longint      bestd;
            longint      dx;
            longint      dy;
            int unsigned best;
            bit          clipped;
            int unsigned ties[TIE_LIMIT];
            int          n_ties;
            qx = longint'($signed(x));
            qy = longint'($signed(y));
            case (cmd) inside
                nps_pkg::CMD_LOAD: begin
                    if (stored_points >= TABLE_DEPTH) begin
                        queue_result(nps_pkg::STAT_FULL, 0, 0, 1'b0, 1'b1);
                    end else begin
                        px[stored_points] = qx;
                        py[stored_points] = qy;
                        queue_result(nps_pkg::STAT_OK, stored_points, 0, 1'b0, 1'b1);
                        stored_points++;
                    end
                end
                nps_pkg::CMD_CLEAR: begin
                    stored_points = 0;
                    queue_result(nps_pkg::STAT_OK, 0, 0, 1'b0, 1'b1);
                end
                nps_pkg::CMD_NEAR, nps_pkg::CMD_ALL: begin
                    if (stored_points == 0) begin
                        queue_result(nps_pkg::STAT_NONE, 0, 0, 1'b0, 1'b1);
                    end else begin
                        bestd   = 0;
                        best    = 0;
                        clipped = 1'b0;
                        n_ties  = 0;
                        for (int unsigned i = 0; i < stored_points; i++) begin
                            d = magnitude(px[i] - qx) + magnitude(py[i] - qy);
                            if (i == 0 || d < bestd) begin
                                bestd   = d;
                                best    = i;
                                ties[0] = i;
                                n_ties  = 1;
                                clipped = 1'b0;
                            end else if (d == bestd) begin
                                if (n_ties < TIE_LIMIT) begin
                                    ties[n_ties] = i;
                                    n_ties++;
                                end else begin
                                    clipped = 1'b1;
                                end
                            end
                        end
                        if (cmd == nps_pkg::CMD_NEAR) begin
                            // exact squared-distance radius test on the first best point
                            dx = magnitude(px[best] - qx);
                            dy = magnitude(py[best] - qy);
                            if (dx * dx + dy * dy > radius * radius)
                                queue_result(nps_pkg::STAT_NONE, 0, 0, 1'b0, 1'b1);
                            else
                                queue_result(nps_pkg::STAT_OK, best, bestd, 1'b0, 1'b1);
                        end else begin
                            for (int k = 0; k < n_ties; k++)
                                queue_result(nps_pkg::STAT_OK, ties[k], bestd, clipped,
                                             k == n_ties - 1);
                        end
                    end
                end
            endcase
        endfunction

        function void compare_field(string name, logic [nps_pkg::DIST_W-1:0] want,
                                    logic [nps_pkg::DIST_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                failures++;
            end
        endfunction

        // Called for every accepted output transaction.
        function void check_response(logic [1:0] status, logic [nps_pkg::IDX_W-1:0] idx,
                                     logic [nps_pkg::DIST_W-1:0] mdist, logic truncated,
                                     logic last);
            t_search_result want;
            if (awaited.size() == 0) begin
                $error("unexpected result: status %0d index %0d dist %0d",
                       status, idx, mdist);
                failures++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status", nps_pkg::DIST_W'(want.status),
                          nps_pkg::DIST_W'(status));
            compare_field("point_index", nps_pkg::DIST_W'(want.point_index),
                          nps_pkg::DIST_W'(idx));
            compare_field("manhattan_dist", want.mdist, mdist);
            compare_field("truncated", nps_pkg::DIST_W'(want.truncated),
                          nps_pkg::DIST_W'(truncated));
            compare_field("last", nps_pkg::DIST_W'(want.last), nps_pkg::DIST_W'(last));
        endfunction
    endclass

endpackage

// File: tb/nearest_point_search_tb.sv
// Testbench top for nearest_point_search: drives stream and config ports, checks results.
// Depends on nps_pkg, search_check_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module nearest_point_search_tb;

    localparam logic [nps_pkg::COORD_W-1:0] COORD_MIN = 20'h80000;
    localparam logic [nps_pkg::COORD_W-1:0] COORD_MAX = 20'h7FFFF;
    localparam logic [nps_pkg::COORD_W-1:0] RADIUS_MAX = 20'hFFFFF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_OFF_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // [19:0] coord_x, [39:20] coord_y
    logic [1:0]  s_axis_tuser = nps_pkg::CMD_LOAD; // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [9:0] point_index, [31:10] manhattan_dist
    logic [2:0]  m_axis_tuser;          // [1:0] status, [2] truncated
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [19:0] i_cfg_wdata = '0;

    search_check_pkg::t_nearest_scoreboard search_sb = new();

    int  cycle_count = 0;
    int  items_sent = 0;
    bit  tx_idle_on = 1'b1;
    bit  rx_idle_on = 1'b1;
    bit  hold_off_go = 1'b0;
    bit  hold_off_done = 1'b0;
    int  hold_left = 0;

    nearest_point_search #(
        .CAPACITY(search_check_pkg::TABLE_DEPTH),
        .MAX_TIES(search_check_pkg::TIE_LIMIT)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL nearest_point_search");
            $finish;
        end
    end

    // Transaction monitor: input transactions feed the predictor, results are checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready === 1'b1)
                search_sb.note_command(nps_pkg::t_cmd'(s_axis_tuser), s_axis_tdata[19:0],
                                       s_axis_tdata[39:20]);
            if (m_axis_tvalid !== 1'b0 && m_axis_tready)
                search_sb.check_response(m_axis_tuser[1:0], m_axis_tdata[9:0],
                                         m_axis_tdata[31:10], m_axis_tuser[2], m_axis_tlast);
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_off_go && !hold_off_done) begin
            hold_left     <= HOLD_OFF_CYCLES;
            hold_off_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle_on) begin
            m_axis_tready <= ($urandom_range(99) >= 14);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(input nps_pkg::t_cmd cmd, input logic [19:0] x,
                             input logic [19:0] y);
        while (tx_idle_on && $urandom_range(99) < 14) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Stop offering, then wait until every predicted result has been taken.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (search_sb.outstanding() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_radius(input logic [19:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        search_sb.set_radius(value);
    endtask

    // One random sequence: mostly a cluster of points on a grid plus nearby queries,
    // sometimes pure noise or a query straight after a clear.
    task automatic random_burst();
        int          kind;
        int          step;
        int          n_pts;
        int          n_q;
        logic [19:0] cx;
        logic [19:0] cy;
        logic [19:0] qx;
        logic [19:0] qy;
        kind = $urandom_range(9);
        step = 1 << $urandom_range(6);
        cx   = 20'($urandom);
        cy   = 20'($urandom);
        if (kind == 0) begin
            repeat ($urandom_range(8, 1))
                send_item(nps_pkg::t_cmd'($urandom_range(3)), 20'($urandom), 20'($urandom));
        end else if (kind == 1) begin
            send_item(nps_pkg::CMD_CLEAR, 20'($urandom), 20'($urandom));
            send_item($urandom_range(1) ? nps_pkg::CMD_NEAR : nps_pkg::CMD_ALL, cx, cy);
        end else begin
            if (search_sb.stored_points > 150 || $urandom_range(99) < 60)
                send_item(nps_pkg::CMD_CLEAR, 20'($urandom), 20'($urandom));
            n_pts = $urandom_range(24, 1);
            repeat (n_pts)
                send_item(nps_pkg::CMD_LOAD, cx + 20'((int'($urandom_range(8)) - 4) * step),
                          cy + 20'((int'($urandom_range(8)) - 4) * step));
            n_q = $urandom_range(6, 1);
            repeat (n_q) begin
                qx = cx + 20'((int'($urandom_range(10)) - 5) * step);
                qy = cy + 20'((int'($urandom_range(10)) - 5) * step);
                if ($urandom_range(3) == 0) begin
                    qx = qx + 20'(int'($urandom_range(6)) - 3);
                    qy = qy + 20'(int'($urandom_range(6)) - 3);
                end
                send_item($urandom_range(1) ? nps_pkg::CMD_NEAR : nps_pkg::CMD_ALL, qx, qy);
            end
        end
    endtask

    initial begin
        logic [19:0] px;
        logic [19:0] py;
        logic [19:0] radii[4];
        int          target;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset radius first.
        send_item(nps_pkg::CMD_NEAR, 20'd0, 20'd0);              // empty table
        send_item(nps_pkg::CMD_ALL, 20'd0, 20'd0);
        send_item(nps_pkg::CMD_LOAD, COORD_MIN, COORD_MIN);
        send_item(nps_pkg::CMD_LOAD, COORD_MAX, COORD_MAX);
        send_item(nps_pkg::CMD_LOAD, 20'd0, 20'd0);
        send_item(nps_pkg::CMD_NEAR, COORD_MAX, COORD_MAX);      // exact hit
        send_item(nps_pkg::CMD_NEAR, COORD_MIN, COORD_MAX);      // three-way tie, far out
        send_item(nps_pkg::CMD_ALL, COORD_MIN, COORD_MAX);
        send_item(nps_pkg::CMD_NEAR, 20'd48, 20'd64);
        send_item(nps_pkg::CMD_CLEAR, COORD_MAX, COORD_MIN);
        send_item(nps_pkg::CMD_ALL, 20'd5, 20'd5);               // query after clear
        send_item(nps_pkg::CMD_LOAD, COORD_MIN, COORD_MIN);
        send_item(nps_pkg::CMD_ALL, COORD_MAX, COORD_MAX);       // largest taxicab distance
        send_item(nps_pkg::CMD_NEAR, COORD_MAX, COORD_MAX);
        wait_drained();
        write_radius(RADIUS_MAX);
        send_item(nps_pkg::CMD_NEAR, COORD_MAX, COORD_MIN);      // on the largest radius
        send_item(nps_pkg::CMD_NEAR, COORD_MAX, 20'hFFFFF);
        wait_drained();
        write_radius(20'd0);
        send_item(nps_pkg::CMD_NEAR, COORD_MIN, COORD_MIN);
        send_item(nps_pkg::CMD_NEAR, COORD_MIN, COORD_MIN + 20'd1);
        wait_drained();
        write_radius(20'd80);
        send_item(nps_pkg::CMD_CLEAR, 20'd0, 20'd0);
        send_item(nps_pkg::CMD_LOAD, 20'd0, 20'd0);
        send_item(nps_pkg::CMD_NEAR, 20'd48, 20'd64);            // 3-4-5 triangle, on radius
        send_item(nps_pkg::CMD_NEAR, 20'd48, 20'd65);

        // Tie list: exactly full, overflow, and reset of the overflow flag.
        px = 20'($urandom);
        py = 20'($urandom);
        send_item(nps_pkg::CMD_CLEAR, 20'd0, 20'd0);
        repeat (search_check_pkg::TIE_LIMIT) send_item(nps_pkg::CMD_LOAD, px, py);
        send_item(nps_pkg::CMD_ALL, px, py - 20'd7);
        send_item(nps_pkg::CMD_LOAD, px, py);
        send_item(nps_pkg::CMD_ALL, px, py - 20'd7);
        send_item(nps_pkg::CMD_LOAD, px + 20'd100, py);
        send_item(nps_pkg::CMD_ALL, px + 20'd3, py);
        send_item(nps_pkg::CMD_NEAR, px + 20'd3, py);
        send_item(nps_pkg::CMD_LOAD, px + 20'd3, py + 20'd1);    // closer point after overflow
        send_item(nps_pkg::CMD_ALL, px + 20'd3, py);

        // Random part, a few radius settings.
        radii[0] = 20'd0;
        radii[1] = RADIUS_MAX;
        radii[2] = 20'($urandom_range(200));
        radii[3] = 20'($urandom);
        target   = items_sent;
        foreach (radii[s]) begin
            wait_drained();
            write_radius(radii[s]);
            target += 65;
            while (items_sent < target) random_burst();
        end

        // No idling; receiver holds off while loads keep coming.
        wait_drained();
        write_radius(RADIUS_MAX);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_item(nps_pkg::CMD_CLEAR, 20'd0, 20'd0);
        hold_off_go <= 1'b1;
        repeat (40) begin
            px = 20'($urandom);
            py = 20'($urandom);
            send_item(nps_pkg::CMD_LOAD, px, py);
        end
        send_item(nps_pkg::CMD_NEAR, px, py);                    // last stored entry
        send_item(nps_pkg::CMD_ALL, 20'($urandom), 20'($urandom));
        send_item(nps_pkg::CMD_CLEAR, 20'd0, 20'd0);
        send_item(nps_pkg::CMD_NEAR, px, py);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (search_sb.failures == 0 && search_sb.outstanding() == 0)
            $display("PASS nearest_point_search");
        else
            $display("FAIL nearest_point_search");
        $finish;
    end

endmodule
